FILE: design/jat_pkg.sv
package jat_pkg;

    // converter sample width
    localparam int SAMPLE_BITS = 12;

    // raw sample after midscale removal, one bit of headroom for negation
    localparam int RAW_W  = SAMPLE_BITS + 1;
    localparam int GAIN_W = 16;
    localparam int OFF_W  = 12;
    localparam int POS_W  = 8;
    localparam int Q_BITS = 12;
    // product of raw and gain plus the offset term, with a carry bit
    localparam int PROD_W = RAW_W + GAIN_W + 1;
    localparam int NUM_W  = PROD_W + 1;
    localparam int M_W    = NUM_W - Q_BITS;

    localparam logic [RAW_W-1:0] MIDSCALE = RAW_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [NUM_W-1:0] Q_ROUND  = NUM_W'((1 << Q_BITS) - 1);
    localparam int STEP_SHIFT = 4;

    localparam logic signed [POS_W-1:0] POS_MAX = 8'sd127;
    localparam logic signed [POS_W-1:0] POS_MIN = -8'sd128;

    localparam int S_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = 2 * POS_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AXIS_INVERT = 3'd0,
        CFG_OFFSET_X    = 3'd1,
        CFG_OFFSET_Y    = 3'd2,
        CFG_GAIN_POS_X  = 3'd3,
        CFG_GAIN_NEG_X  = 3'd4,
        CFG_GAIN_POS_Y  = 3'd5,
        CFG_GAIN_NEG_Y  = 3'd6,
        CFG_DZ_RADIUS   = 3'd7
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;

    // stage load strobes shared by the lanes and the merge stage
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
    } jat_ctrl_t;

endpackage

FILE: design/jat_lane.sv
module jat_lane (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  jat_pkg::jat_ctrl_t                       ctrl,
    input  logic [jat_pkg::SAMPLE_BITS-1:0]          sample,
    input  logic                                     keep,
    input  logic signed [jat_pkg::OFF_W-1:0]         offset,
    input  logic [jat_pkg::GAIN_W-1:0]               gain_pos,
    input  logic [jat_pkg::GAIN_W-1:0]               gain_neg,
    output logic signed [jat_pkg::POS_W-1:0]         pos
);
    import jat_pkg::*;

    logic signed [RAW_W-1:0]    raw;
    logic signed [RAW_W-1:0]    v;
    logic [GAIN_W-1:0]          gsel;
    logic signed [PROD_W-1:0]   prod;
    logic signed [OFF_W:0]      off_s;
    logic signed [NUM_W-1:0]    off_term;
    logic signed [NUM_W-1:0]    num_next;
    logic signed [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]           num_adj;
    logic signed [M_W-1:0]      m;
    logic signed [M_W-1:0]      pos_ext;
    logic signed [M_W-1:0]      hi_lim;
    logic signed [M_W-1:0]      lo_lim;
    logic signed [POS_W-1:0]    pos_reg;
    logic signed [POS_W-1:0]    pos_next;

    // stage a: centre, flip, gain and offset
    assign raw      = $signed(RAW_W'(sample) - MIDSCALE);
    assign v        = keep ? raw : -raw;
    assign gsel     = v[RAW_W-1] ? gain_neg : gain_pos;
    assign prod     = PROD_W'(v) * $signed(PROD_W'(gsel));
    assign off_s    = keep ? (OFF_W+1)'(offset) : -((OFF_W+1)'(offset));
    assign off_term = NUM_W'(off_s) <<< Q_BITS;
    assign num_next = NUM_W'(prod) + off_term;

    always_ff @(posedge aclk) begin
        if (ctrl.load_a) begin
            num_reg <= num_next;
        end
    end

    // stage b: truncate toward zero, then one step of tracking
    assign num_adj = num_reg[NUM_W-1] ? (num_reg + Q_ROUND) : num_reg;
    assign m       = $signed(num_adj[NUM_W-1:Q_BITS]);
    assign pos_ext = M_W'(pos_reg);
    assign hi_lim  = (pos_ext + M_W'(1)) <<< STEP_SHIFT;
    assign lo_lim  = (pos_ext - M_W'(1)) <<< STEP_SHIFT;

    always_comb begin
        pos_next = pos_reg;
        if (m > hi_lim) begin
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end else if (m < lo_lim) begin
            if (pos_reg != POS_MIN) begin
                pos_next = pos_reg - POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (ctrl.load_b) begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

FILE: design/jat_merge.sv
module jat_merge (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  jat_pkg::jat_ctrl_t                    ctrl,
    input  logic                                  m_tready,
    input  logic signed [jat_pkg::POS_W-1:0]      pos_x,
    input  logic signed [jat_pkg::POS_W-1:0]      pos_y,
    input  logic [7:0]                            radius,
    output logic                                  m_tvalid,
    output logic [jat_pkg::M_DATA_W-1:0]          m_tdata
);
    import jat_pkg::*;

    logic signed [2*POS_W-1:0]  x2;
    logic signed [2*POS_W-1:0]  y2;
    logic [15:0]                sq_sum;
    logic [15:0]                r2;
    logic                       in_zone;
    logic                       out_valid_reg;
    logic [M_DATA_W-1:0]        out_data_reg;

    assign x2      = (2*POS_W)'(pos_x) * (2*POS_W)'(pos_x);
    assign y2      = (2*POS_W)'(pos_y) * (2*POS_W)'(pos_y);
    // both squares are at most 2^14, so their sum fits 16 bits
    assign sq_sum  = 16'(x2[2*POS_W-2:0]) + 16'(y2[2*POS_W-2:0]);
    assign r2      = 16'(radius) * 16'(radius);
    assign in_zone = sq_sum < r2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.load_c) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_c) begin
            out_data_reg <= in_zone ? '0 : {pos_y, pos_x};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: design/joystick_axis_tracker_deadzone.sv
// joystick axis tracker with circular deadzone
//
// input channel (s_): one item carries one 12-bit converter sample per axis,
// x in the low bits of s_tdata and y above it. result channel (m_): one item
// per input item with the signed 8-bit x and y positions.
// each axis runs in its own lane: centre removal, optional sign flip, offset
// and split gain (Q4.12) in the first stage, then a one-count step of the
// stored position toward the measure in the second. a merge stage applies
// the circular deadzone and holds the output register.
// an accepted item moves through the stage a register, the stored position
// and the output register, which drives m_tvalid. throughput: one item per
// cycle unless the output stalls; the lane position update loop keeps pace.
// stalls: every stage loads when it or the next stage is empty or moving, so
// input is still taken while a result waits, until the pipeline is full.
// reset (aresetn low, synchronous) empties the pipeline, zeroes both stored
// positions and returns the registers to unity gain, zero offset, no flip
// and no deadzone. registers are written through cfg_we/cfg_addr/cfg_wdata;
// write them only while the block is idle; the block does not enforce this.
module joystick_axis_tracker_deadzone (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // sample_x, sample_y
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [jat_pkg::S_DATA_W-1:0]         s_tdata,
    // pos_x, pos_y
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [jat_pkg::M_DATA_W-1:0]         m_tdata,
    // register write port
    input  logic                                 cfg_we,
    input  logic [jat_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [jat_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import jat_pkg::*;

    // configuration registers
    logic [1:0]              axis_invert_reg;
    logic signed [OFF_W-1:0] offset_x_reg;
    logic signed [OFF_W-1:0] offset_y_reg;
    logic [GAIN_W-1:0]       gain_pos_x_reg;
    logic [GAIN_W-1:0]       gain_neg_x_reg;
    logic [GAIN_W-1:0]       gain_pos_y_reg;
    logic [GAIN_W-1:0]       gain_neg_y_reg;
    logic [7:0]              dz_radius_reg;

    // pipeline occupancy
    logic                    valid_a_reg;
    logic                    valid_b_reg;
    logic                    ready_a;
    logic                    ready_b;
    logic                    ready_c;
    jat_ctrl_t               ctrl;

    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    // register writes, index decoded by name
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_invert_reg <= 2'b11;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            gain_pos_x_reg  <= GAIN_ONE;
            gain_neg_x_reg  <= GAIN_ONE;
            gain_pos_y_reg  <= GAIN_ONE;
            gain_neg_y_reg  <= GAIN_ONE;
            dz_radius_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_AXIS_INVERT: axis_invert_reg <= cfg_wdata[1:0];
                CFG_OFFSET_X:    offset_x_reg    <= $signed(cfg_wdata[OFF_W-1:0]);
                CFG_OFFSET_Y:    offset_y_reg    <= $signed(cfg_wdata[OFF_W-1:0]);
                CFG_GAIN_POS_X:  gain_pos_x_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_NEG_X:  gain_neg_x_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_POS_Y:  gain_pos_y_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_NEG_Y:  gain_neg_y_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_DZ_RADIUS:   dz_radius_reg   <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // ready ripples back from the output register
    assign ready_c  = !m_tvalid || m_tready;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign s_tready = ready_a;

    assign ctrl.load_a = s_tvalid && ready_a;
    assign ctrl.load_b = valid_a_reg && ready_b;
    assign ctrl.load_c = valid_b_reg && ready_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (ctrl.load_a) begin
                valid_a_reg <= 1'b1;
            end else if (ctrl.load_b) begin
                valid_a_reg <= 1'b0;
            end
            if (ctrl.load_b) begin
                valid_b_reg <= 1'b1;
            end else if (ctrl.load_c) begin
                valid_b_reg <= 1'b0;
            end
        end
    end

    // x lane
    jat_lane u_lane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .keep     (axis_invert_reg[0]),
        .offset   (offset_x_reg),
        .gain_pos (gain_pos_x_reg),
        .gain_neg (gain_neg_x_reg),
        .pos      (pos_x)
    );

    // y lane
    jat_lane u_lane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .keep     (axis_invert_reg[1]),
        .offset   (offset_y_reg),
        .gain_pos (gain_pos_y_reg),
        .gain_neg (gain_neg_y_reg),
        .pos      (pos_y)
    );

    // deadzone and output register
    jat_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .m_tready (m_tready),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .radius   (dz_radius_reg),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/jat_checker.sv
module jat_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [jat_pkg::M_DATA_W-1:0]      m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty output register means the pipeline can take an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output empty");

    // with the receiver ready, an accepted item reaches the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after flowing pipeline");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind joystick_axis_tracker_deadzone jat_checker u_jat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
